FILE: src/skle_pkg.sv
package skle_pkg;

    localparam int KEY_W    = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INS_ORDERED = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_FRONT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_END     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_KEY     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIND        = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             compare;   // latch match flag
        logic             ordered;   // flag = key >= op key, else key == op key
        logic             shift;     // flags move one cell toward the front
        logic             load_ins;  // insert op key at op position
        logic             load_del;  // close the entry at op position
        logic [KEY_W-1:0] key;
    } cell_ctrl_t;

endpackage

FILE: src/sorted_key_list_engine.sv
// Sorted key list engine: an ordered list of up to DEPTH signed 32-bit keys.
// Input channel (in_valid/in_ready) carries command and key; output channel
// (out_valid/out_ready) carries status, position and count, one result per
// transfer in, in order. Inserts into a full list are dropped with status full.
// Commands: ordered insert, insert front, insert end, delete key, delete
// front, find.
// Storage is a row of key cells. Each cell compares its own key against the
// broadcast key in parallel; the resulting match flags then move one cell per
// cycle toward the front, where the controller watches cell 0 and counts.
// Once the position is known, the cells from there on all shift by one.
// Front/end insert, delete front and the full/empty/unused cases go
// straight to the apply state; ordered insert, delete key and find first
// compare, then scan the flags through the cell row. in_ready returns with
// the result, so no new command is taken while one is still in progress.
// A new item is taken while the previous result still waits in the output
// register; if the receiver stalls, it finishes its search and holds.
// Reset clears the count and all control; key cells are not cleared and are
// read only after being written.
module sorted_key_list_engine #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [skle_pkg::CMD_W-1:0]    command,
    input  logic signed [skle_pkg::KEY_W-1:0] key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [skle_pkg::STATUS_W-1:0] status,
    output logic [skle_pkg::POS_W-1:0]    position,
    output logic [skle_pkg::COUNT_W-1:0]  count
);
    import skle_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cell_ctrl_t        ctrl;
    logic [IDX_W-1:0]  op_pos;
    logic [CNT_W-1:0]  entry_count;
    logic [KEY_W-1:0]  cell_key [DEPTH];
    logic              cell_flag [DEPTH];

    skle_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .position    (position),
        .count       (count),
        .head_flag   (cell_flag[0]),
        .ctrl        (ctrl),
        .op_pos      (op_pos),
        .entry_count (entry_count)
    );

    // cell i takes from i-1 on insert and from i+1 on delete / flag shift
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0] left_key;
        logic [KEY_W-1:0] right_key;
        logic             right_flag;

        if (i == 0)
        begin : g_first
            assign left_key = ctrl.key;
        end
        else
        begin : g_mid_l
            assign left_key = cell_key[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_key  = cell_key[i];
            assign right_flag = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_key  = cell_key[i+1];
            assign right_flag = cell_flag[i+1];
        end

        skle_cell #(
            .DEPTH(DEPTH),
            .INDEX(i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .op_pos      (op_pos),
            .entry_count (entry_count),
            .left_key    (left_key),
            .right_key   (right_key),
            .right_flag  (right_flag),
            .key_q       (cell_key[i]),
            .flag_q      (cell_flag[i])
        );
    end

endmodule

FILE: src/skle_cell.sv
module skle_cell #(
    parameter int DEPTH = 16,
    parameter int INDEX = 0,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  skle_pkg::cell_ctrl_t     ctrl,
    input  logic [IDX_W-1:0]         op_pos,
    input  logic [CNT_W-1:0]         entry_count,
    input  logic [skle_pkg::KEY_W-1:0] left_key,
    input  logic [skle_pkg::KEY_W-1:0] right_key,
    input  logic                     right_flag,
    output logic [skle_pkg::KEY_W-1:0] key_q,
    output logic                     flag_q
);
    import skle_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             flag_reg;
    logic             flag_next;
    logic             occupied;
    logic             hit;

    assign occupied = MY_CNT < entry_count;
    assign hit = ctrl.ordered ? !($signed(key_reg) < $signed(ctrl.key))
                              : (key_reg == ctrl.key);

    always_comb
    begin
        flag_next = flag_reg;
        if (ctrl.compare)
        begin
            flag_next = occupied && hit;
        end
        else if (ctrl.shift)
        begin
            flag_next = right_flag;
        end
    end

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.load_ins)
        begin
            if (MY_IDX == op_pos)
            begin
                key_next = ctrl.key;
            end
            else if (MY_IDX > op_pos)
            begin
                key_next = left_key;
            end
        end
        else if (ctrl.load_del)
        begin
            if (MY_IDX >= op_pos)
            begin
                key_next = right_key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_q  = key_reg;
    assign flag_q = flag_reg;

endmodule

FILE: src/skle_ctrl.sv
module skle_ctrl #(
    parameter int DEPTH = 16,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [skle_pkg::CMD_W-1:0]    command,
    input  logic [skle_pkg::KEY_W-1:0]    key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [skle_pkg::STATUS_W-1:0] status,
    output logic [skle_pkg::POS_W-1:0]    position,
    output logic [skle_pkg::COUNT_W-1:0]  count,
    input  logic                          head_flag,
    output skle_pkg::cell_ctrl_t          ctrl,
    output logic [IDX_W-1:0]              op_pos,
    output logic [CNT_W-1:0]              entry_count
);
    import skle_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SCAN,
        S_APPLY
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INS,
        ACT_DEL
    } act_t;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t               state_reg, state_next;
    act_t                 act_reg, act_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [STATUS_W-1:0]  st_reg, st_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [POS_W-1:0]     out_pos_reg, out_pos_next;
    logic [COUNT_W-1:0]   out_cnt_reg, out_cnt_next;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic                 fire;
    logic                 scan_last;
    logic [IDX_W+POS_W-1:0]   pos_ext;
    logic [CNT_W+COUNT_W-1:0] cnt_ext;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign full      = (cnt_reg == FULL_CNT);
    assign empty     = (cnt_reg == '0);
    assign fire      = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);
    assign scan_last = ((CNT_W'(pos_reg) + CNT_W'(1)) == cnt_reg);
    assign pos_ext   = {{POS_W{1'b0}}, pos_reg};

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        st_next         = st_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_cnt_next    = out_cnt_reg;
        cnt_ext         = {{COUNT_W{1'b0}}, cnt_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = command;
                    key_next   = key;
                    pos_next   = '0;
                    st_next    = ST_DONE;
                    act_next   = ACT_NONE;
                    state_next = S_APPLY;
                    priority case (command)
                        CMD_INS_ORDERED:
                        begin
                            if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else if (empty)
                            begin
                                act_next = ACT_INS;
                            end
                            else
                            begin
                                state_next = S_CMP;
                            end
                        end
                        CMD_INS_FRONT:
                        begin
                            if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                act_next = ACT_INS;
                            end
                        end
                        CMD_INS_END:
                        begin
                            if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                act_next = ACT_INS;
                                pos_next = cnt_reg[IDX_W-1:0];
                            end
                        end
                        CMD_DEL_KEY, CMD_FIND:
                        begin
                            if (empty)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_CMP;
                            end
                        end
                        CMD_DEL_FRONT:
                        begin
                            if (empty)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                act_next = ACT_DEL;
                            end
                        end
                        default:
                        begin
                            act_next = ACT_NONE;
                        end
                    endcase
                end
            end
            S_CMP:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (head_flag)
                begin
                    state_next = S_APPLY;
                    st_next    = ST_DONE;
                    priority case (cmd_reg)
                        CMD_INS_ORDERED: act_next = ACT_INS;
                        CMD_DEL_KEY:     act_next = ACT_DEL;
                        default:         act_next = ACT_NONE;
                    endcase
                end
                else if (scan_last)
                begin
                    state_next = S_APPLY;
                    if (cmd_reg == CMD_INS_ORDERED)
                    begin
                        // nothing not less than the key: append
                        act_next = ACT_INS;
                        st_next  = ST_DONE;
                        pos_next = cnt_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        act_next = ACT_NONE;
                        st_next  = ST_NOT_FOUND;
                        pos_next = '0;
                    end
                end
                else
                begin
                    pos_next = pos_reg + IDX_W'(1);
                end
            end
            S_APPLY:
            begin
                if (fire)
                begin
                    unique case (act_reg)
                        ACT_INS:  cnt_next = cnt_reg + CNT_W'(1);
                        ACT_DEL:  cnt_next = cnt_reg - CNT_W'(1);
                        default:  cnt_next = cnt_reg;
                    endcase
                    cnt_ext         = {{COUNT_W{1'b0}}, cnt_next};
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_pos_next    = pos_ext[POS_W-1:0];
                    out_cnt_next    = cnt_ext[COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_reg        <= ACT_NONE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            cmd_reg        <= '0;
            key_reg        <= '0;
            pos_reg        <= '0;
            st_reg         <= ST_DONE;
            out_status_reg <= ST_DONE;
            out_pos_reg    <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            act_reg        <= act_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            cmd_reg        <= cmd_next;
            key_reg        <= key_next;
            pos_reg        <= pos_next;
            st_reg         <= st_next;
            out_status_reg <= out_status_next;
            out_pos_reg    <= out_pos_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    always_comb
    begin
        ctrl.compare  = (state_reg == S_CMP);
        ctrl.ordered  = (cmd_reg == CMD_INS_ORDERED);
        ctrl.shift    = (state_reg == S_SCAN);
        ctrl.load_ins = fire && (act_reg == ACT_INS);
        ctrl.load_del = fire && (act_reg == ACT_DEL);
        ctrl.key      = key_reg;
    end

    assign op_pos      = pos_reg;
    assign entry_count = cnt_reg;
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign position    = out_pos_reg;
    assign count       = out_cnt_reg;

endmodule

FILE: bench/skle_checker.sv
`timescale 1ns / 100ps

module skle_checker #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [skle_pkg::CMD_W-1:0]        command,
    input  logic signed [skle_pkg::KEY_W-1:0] key,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [skle_pkg::STATUS_W-1:0]     status,
    input  logic [skle_pkg::POS_W-1:0]        position,
    input  logic [skle_pkg::COUNT_W-1:0]      count,
    output int                                fail_count,
    output int                                pending
);
    import skle_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    // shadow of the key list, front at index 0
    logic signed [KEY_W-1:0] list_keys [DEPTH];
    int unsigned             list_len;

    list_result_t expected_results [$];
    int           errors;

    function automatic void close_gap(input int unsigned at);
        int unsigned i;
        for (i = at; i + 1 < list_len; i++)
        begin
            list_keys[i] = list_keys[i + 1];
        end
        list_len--;
    endfunction

    // applies one command to the shadow list, returns the answer it must give
    function automatic list_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [KEY_W-1:0] k);
        list_result_t r;
        int unsigned  at;
        int unsigned  i;
        bit           hit;
        r.status = ST_DONE;
        at = 0;
        case (cmd)
            CMD_INS_ORDERED, CMD_INS_FRONT, CMD_INS_END:
            begin
                if (list_len >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    if (cmd == CMD_INS_END)
                    begin
                        at = list_len;
                    end
                    else if (cmd == CMD_INS_ORDERED)
                    begin
                        // goes ahead of the first key not less than k
                        while (at < list_len && list_keys[at] < k)
                        begin
                            at++;
                        end
                    end
                    for (i = list_len; i > at; i--)
                    begin
                        list_keys[i] = list_keys[i - 1];
                    end
                    list_keys[at] = k;
                    list_len++;
                end
            end
            CMD_DEL_KEY, CMD_FIND:
            begin
                if (list_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    hit = 1'b0;
                    for (i = 0; i < list_len && !hit; i++)
                    begin
                        if (list_keys[i] == k)
                        begin
                            hit = 1'b1;
                            at  = i;
                        end
                    end
                    if (!hit)
                    begin
                        r.status = ST_NOT_FOUND;
                        at = 0;
                    end
                    else if (cmd == CMD_DEL_KEY)
                    begin
                        close_gap(at);
                    end
                end
            end
            CMD_DEL_FRONT:
            begin
                if (list_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    close_gap(0);
                end
            end
            default:
            begin
                // spare codes leave the list alone
            end
        endcase
        r.position = at[POS_W-1:0];
        r.count    = list_len[COUNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        list_result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            list_len   = 0;
            errors     = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // a result never leaves in the cycle its command arrives, so
            // checking before predicting keeps the order right
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, status, position, count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("position", 32'(want.position), 32'(position));
                    check_field("count", 32'(want.count), 32'(count));
                end
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(apply_command(command, key));
            end
            fail_count <= errors;
            pending    <= expected_results.size();
        end
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import skle_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_ITEMS   = 1680;
    // keep well clear of the slowest legal run
    localparam int CYCLE_LIMIT    = 500000;
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
    // one long receiver stall, started after this many result transfers
    localparam int HOLD_AT_RESULT = 500;
    localparam int HOLD_CYCLES    = 300;

    // command codes the block does not define; they must be answered as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W - 1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W - 1){1'b1}}};

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic [CMD_W-1:0]        command   = '0;
    logic signed [KEY_W-1:0] key       = '0;
    logic                    out_ready = 1'b0;
    logic                    in_ready;
    logic                    out_valid;
    logic [STATUS_W-1:0]     status;
    logic [POS_W-1:0]        position;
    logic [COUNT_W-1:0]      count;

    int fail_count;
    int pending;
    int cycles = 0;

    // when set, the side concerned runs back to back with no idle cycles
    bit sender_burst   = 1'b0;
    bit receiver_burst = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_key_list_engine #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .key      (key),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .position (position),
        .count    (count)
    );

    skle_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .position  (position),
        .count     (count),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // One command transfer. Called right after a rising edge; returns right
    // after the edge that took the command. A zero gap keeps valid high, so
    // valid gets a single assignment per edge.
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic signed [KEY_W-1:0] k);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        key      <= k;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Result side: random stall before each transfer, bursts with no stall,
    // and one long hold-off so the block backs up and drops in_ready while
    // the sender keeps offering commands.
    initial
    begin : result_sink
        int taken;
        int hold;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 64 == 0)
            begin
                receiver_burst = ($urandom_range(0, 3) == 0);
            end
            if (taken == HOLD_AT_RESULT)
            begin
                hold = HOLD_CYCLES;
            end
            else
            begin
                hold = receiver_burst ? 0 : $urandom_range(0, 16);
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    initial
    begin : stimulus
        int                      n;
        int                      roll;
        int                      ins_share;
        int                      phase;
        logic [CMD_W-1:0]        cmd;
        logic signed [KEY_W-1:0] k;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // commands that need entries, on an empty list
        send_command(CMD_DEL_FRONT, 32'sd0);
        send_command(CMD_FIND, 32'sd0);
        send_command(CMD_DEL_KEY, KEY_MAX);
        // spare codes are no-ops
        send_command(CMD_SPARE_A, -32'sd1);
        send_command(CMD_SPARE_B, KEY_MAX);
        // ordered inserts: equal key at the head goes in front of it,
        // then the key extremes land at both ends
        send_command(CMD_INS_ORDERED, 32'sd5);
        send_command(CMD_INS_ORDERED, 32'sd5);
        send_command(CMD_INS_ORDERED, KEY_MAX);
        send_command(CMD_INS_ORDERED, KEY_MIN);
        send_command(CMD_INS_ORDERED, -32'sd1);
        send_command(CMD_INS_ORDERED, 32'sd0);
        // front and end inserts ignore ordering
        send_command(CMD_INS_FRONT, 32'sd7);
        send_command(CMD_INS_END, -32'sd7);
        // hits, first of two duplicates, and misses
        send_command(CMD_FIND, 32'sd5);
        send_command(CMD_FIND, KEY_MAX);
        send_command(CMD_FIND, 32'sd123);
        send_command(CMD_DEL_KEY, 32'sd5);
        send_command(CMD_DEL_KEY, 32'sd999);
        send_command(CMD_DEL_FRONT, KEY_MIN);

        // --- random part ---
        // Phases rotate grow / drain / mixed so the list reaches full (drops)
        // and empty repeatedly. Keys mostly come from a small pool so finds
        // and deletes hit and duplicates appear; the rest are extremes or
        // fully random words. Spare codes are noise and are not counted.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (n % 64 == 0)
            begin
                sender_burst = ($urandom_range(0, 3) == 0);
            end
            phase = (n / 120) % 3;
            case (phase)
                0:       ins_share = 75;
                1:       ins_share = 15;
                default: ins_share = 50;
            endcase

            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                cmd = (roll == 0) ? CMD_SPARE_A : CMD_SPARE_B;
            end
            else if ($urandom_range(0, 99) < ins_share)
            begin
                case ($urandom_range(0, 3))
                    0, 1:    cmd = CMD_INS_ORDERED;
                    2:       cmd = CMD_INS_FRONT;
                    default: cmd = CMD_INS_END;
                endcase
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_DEL_KEY;
                    1:       cmd = CMD_DEL_FRONT;
                    default: cmd = CMD_FIND;
                endcase
            end

            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                k = int'($urandom_range(0, 12)) - 6;
            end
            else if (roll < 75)
            begin
                case ($urandom_range(0, 5))
                    0:       k = KEY_MIN;
                    1:       k = KEY_MIN + 1;
                    2:       k = KEY_MAX;
                    3:       k = KEY_MAX - 1;
                    4:       k = '0;
                    default: k = '1;
                endcase
            end
            else
            begin
                k = $urandom;
            end

            send_command(cmd, k);
            if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B)
            begin
                n++;
            end
        end
        in_valid <= 1'b0;

        // let every outstanding result arrive, then watch for stray ones
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
